// ----- hdl/io_interrupt_router_core_assert.svh -----
// Assertion macros shared by the interrupt router RTL.
`ifndef IO_INTERRUPT_ROUTER_CORE_ASSERT_SVH
`define IO_INTERRUPT_ROUTER_CORE_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define IORC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define IORC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/iorc_pkg.sv -----
// Types and constants of the I/O interrupt router.
`default_nettype none
package iorc_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_EOI   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_MSG  = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_MASK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DELIV  = 2'd1,
        ST_COAL   = 2'd2,
        ST_MASKED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SZ_NONE = 2'd0,
        SZ_BYTE = 2'd1,
        SZ_HALF = 2'd2,
        SZ_WORD = 2'd3
    } t_size;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WNOTE,
        S_SVC,
        S_EOI,
        S_DONE
    } t_state;

    localparam logic [7:0]  OFF_SELECT  = 8'h00;
    localparam logic [7:0]  OFF_WINDOW  = 8'h10;
    localparam logic [31:0] SEL_ID      = 32'd0;
    localparam logic [31:0] SEL_VERSION = 32'd1;
    localparam logic [31:0] SEL_ARB     = 32'd2;
    localparam logic [31:0] TABLE_BASE  = 32'h10;

    localparam int BIT_DEST_LOGICAL = 11;
    localparam int BIT_POLARITY     = 13;
    localparam int BIT_REMOTE       = 14;
    localparam int BIT_LEVEL        = 15;
    localparam int BIT_MASK         = 16;

    localparam logic [63:0] ENTRY_RESET = 64'h1 << BIT_MASK;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  reg_offset;
        logic [3:0]  access_bytes;
        logic [31:0] write_data;
        logic [4:0]  pin;
        logic        line_level;
        logic [7:0]  eoi_vector;
        logic        eoi_level_trig;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] read_data;
        logic [1:0]  line_status;
        logic [7:0]  msg_dest;
        logic [7:0]  msg_vector;
        logic        msg_dest_logical;
        logic        msg_level_trig;
        logic [2:0]  msg_delivery_mode;
        logic [4:0]  note_pin;
        logic        note_masked;
        logic        last;
    } t_rsp;

    // Decoded request held in the queue between front and back.
    typedef struct packed {
        t_cmd        cmd;
        logic        off_sel;
        logic        off_win;
        t_size       size;
        logic [31:0] data;
        logic [4:0]  pin;
        logic        level;
        logic [7:0]  vector;
        logic        eoi_level;
    } t_job;

    typedef struct packed {
        logic [7:0] boot_cpu_id;
        logic [7:0] version_number;
    } t_cfg;

endpackage
`default_nettype wire

// ----- hdl/iorc_if.sv -----
// Request and response channel interfaces.
`default_nettype none
interface iorc_req_if;
    import iorc_pkg::*;
    logic valid;
    logic ready;
    t_req item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface iorc_rsp_if;
    import iorc_pkg::*;
    logic valid;
    logic ready;
    t_rsp rsp;
    modport source (output valid, output rsp, input ready);
    modport sink   (input valid, input rsp, output ready);
endinterface
`default_nettype wire

// ----- hdl/io_interrupt_router_core.sv -----
// A read, select write or line change passes the idle, execute and done states in turn;
// a delivering line change adds the service state. An end of interrupt walks the table
// and redelivers where due. Only one request is executed at a time.
// A two-entry queue takes new requests while the executor or response register stalls.
// Reset (synchronous, active low): entries masked, pending lines, select and id cleared,
// boot id 0, version 17; no clearing pass, the block is ready the cycle after reset.
`default_nettype none
module io_interrupt_router_core #(
    parameter int PIN_COUNT = 24
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire [0:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_wdata,
    iorc_req_if.sink   i_req,
    iorc_rsp_if.source o_rsp
);
    import iorc_pkg::*;

    `include "io_interrupt_router_core_assert.svh"

    localparam logic [0:0] CFG_BOOT_ID = 1'b0;
    localparam logic [0:0] CFG_VERSION = 1'b1;

    // Configuration registers: the user must write them only while the block is idle; not enforced here.
    t_cfg r_cfg;
    t_job job;
    logic job_valid;
    logic job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boot_cpu_id    <= 8'd0;
            r_cfg.version_number <= 8'd17;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BOOT_ID: r_cfg.boot_cpu_id    <= i_cfg_wdata;
                CFG_VERSION: r_cfg.version_number <= i_cfg_wdata;
                default:     r_cfg                <= r_cfg;
            endcase
        end
    end

    // Front: decode each request and hold it in the queue.
    iorc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    // Back: run the request against the routing table, one result at a time.
    iorc_back #(
        .PIN_COUNT (PIN_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_rsp       (o_rsp)
    );

    // Only the completion ends a request.
    `IORC_ASSERT_IMPLY(a_last_on_done, i_clk, i_rst_n,
        o_rsp.valid, (o_rsp.rsp.last == (o_rsp.rsp.result_kind == KIND_DONE)),
        "last flag disagrees with result kind")
    // Line status travels on completions only.
    `IORC_ASSERT_IMPLY(a_status_on_done, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.rsp.result_kind != KIND_DONE, o_rsp.rsp.line_status == ST_NONE,
        "line status on a non-completion result")
    // Messages and notices name a pin of the table.
    `IORC_ASSERT_IMPLY(a_pin_range, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.rsp.result_kind != KIND_DONE,
        o_rsp.rsp.note_pin < 5'(PIN_COUNT), "result names a pin outside the table")
    // An accepted request is visible to the executor next cycle.
    `IORC_ASSERT_NEXT(a_queue_fill, i_clk, i_rst_n,
        i_req.valid && i_req.ready, job_valid, "accepted request lost by the queue")
endmodule
`default_nettype wire

// ----- hdl/iorc_front.sv -----
// Request front end: decode and two-entry queue toward the executor.
`default_nettype none
module iorc_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    iorc_req_if.sink       i_req,
    output iorc_pkg::t_job o_job,
    output logic           o_job_valid,
    input  wire            i_job_pop
);
    import iorc_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       dec;
    logic       push;

    always_comb begin
        dec.cmd       = t_cmd'(i_req.item.command);
        dec.off_sel   = (i_req.item.reg_offset == OFF_SELECT);
        dec.off_win   = (i_req.item.reg_offset == OFF_WINDOW);
        unique case (i_req.item.access_bytes)
            4'd1:       dec.size = SZ_BYTE;
            4'd2:       dec.size = SZ_HALF;
            4'd4, 4'd8: dec.size = SZ_WORD;
            default:    dec.size = SZ_NONE;
        endcase
        dec.data      = i_req.item.write_data;
        dec.pin       = i_req.item.pin;
        dec.level     = i_req.item.line_level;
        dec.vector    = i_req.item.eoi_vector;
        dec.eoi_level = i_req.item.eoi_level_trig;
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_pop);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/iorc_back.sv -----
// Executor: routing table, pin state, sequencer and response register.
`default_nettype none
module iorc_back #(
    parameter int PIN_COUNT = 24
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  iorc_pkg::t_cfg i_cfg,
    input  iorc_pkg::t_job i_job,
    input  wire            i_job_valid,
    output logic           o_job_pop,
    iorc_rsp_if.source     o_rsp
);
    import iorc_pkg::*;

    localparam int IW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PIN_COUNT - 1);
    localparam logic [7:0]    MAX_PIN  = 8'(PIN_COUNT - 1);

    t_state         r_state, n_state;
    logic [63:0]    r_tbl [PIN_COUNT];
    logic [PIN_COUNT-1:0] r_pend, n_pend;
    logic [31:0]    r_sel, n_sel;
    logic [3:0]     r_uid, n_uid;
    t_job           r_job, n_job;
    logic [IW-1:0]  r_idx, n_idx;
    logic           r_idx_ok, n_idx_ok;
    logic           r_eoi, n_eoi;
    logic           r_mchg, n_mchg;
    logic [31:0]    r_rd, n_rd;
    t_status        r_status, n_status;
    t_rsp           r_out, n_out;
    logic           r_out_valid;

    logic           emit;
    logic           can_emit;
    logic           tbl_we;
    logic [63:0]    tbl_wdata;
    logic [63:0]    ent;
    logic [63:0]    nent;
    logic [31:0]    sel_off;
    logic [31:0]    win;
    logic [31:0]    val;
    logic           active;
    logic           serve;
    logic           pend_bit;

    assign ent      = r_tbl[r_idx];
    assign pend_bit = r_pend[r_idx];
    assign can_emit = !r_out_valid || o_rsp.ready;
    assign sel_off  = r_sel - TABLE_BASE;

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_sel     = r_sel;
        n_uid     = r_uid;
        n_job     = r_job;
        n_idx     = r_idx;
        n_idx_ok  = r_idx_ok;
        n_eoi     = r_eoi;
        n_mchg    = r_mchg;
        n_rd      = r_rd;
        n_status  = r_status;
        n_out     = '0;
        emit      = 1'b0;
        o_job_pop = 1'b0;
        tbl_we    = 1'b0;
        tbl_wdata = ent;
        nent      = ent;
        win       = '0;
        val       = '0;
        active    = 1'b0;
        serve     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_rd      = '0;
                    n_status  = ST_NONE;
                    n_mchg    = 1'b0;
                    n_eoi     = (i_job.cmd == CMD_EOI);
                    n_idx     = '0;
                    n_idx_ok  = 1'b0;
                    if (i_job.cmd == CMD_LINE) begin
                        n_idx_ok = (i_job.pin < 5'(PIN_COUNT));
                        if (n_idx_ok) begin
                            n_idx = i_job.pin[IW-1:0];
                        end
                    end else if (i_job.cmd != CMD_EOI) begin
                        n_idx_ok = (sel_off[31:1] < 31'(PIN_COUNT));
                        if (n_idx_ok) begin
                            n_idx = sel_off[IW:1];
                        end
                    end
                    n_state = (i_job.cmd == CMD_EOI) ? S_EOI : S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_job.cmd)
                    CMD_READ: begin
                        if (r_sel == SEL_VERSION) begin
                            win = {8'h00, MAX_PIN, 8'h00, i_cfg.version_number};
                        end else if (r_sel == SEL_ID || r_sel == SEL_ARB) begin
                            win = {4'h0, r_uid, 24'h0};
                        end else if (r_idx_ok) begin
                            win = r_sel[0] ? ent[63:32] : ent[31:0];
                        end else begin
                            win = '1;
                        end
                        if (r_job.off_sel) begin
                            val = r_sel;
                        end else if (r_job.off_win) begin
                            val = win;
                        end
                        unique case (r_job.size)
                            SZ_BYTE: n_rd = {24'h0, val[7:0]};
                            SZ_HALF: n_rd = {16'h0, val[15:0]};
                            SZ_WORD: n_rd = val;
                            default: n_rd = '0;
                        endcase
                    end
                    CMD_WRITE: begin
                        if (r_job.size == SZ_WORD) begin
                            if (r_job.off_sel) begin
                                n_sel = r_job.data;
                            end else if (r_job.off_win) begin
                                if (r_sel == SEL_ID) begin
                                    n_uid = r_job.data[27:24];
                                end else if (r_sel != SEL_VERSION && r_sel != SEL_ARB
                                             && r_idx_ok) begin
                                    if (r_sel[0]) begin
                                        nent = {r_job.data, ent[31:0]};
                                    end else begin
                                        nent = {ent[63:32], r_job.data};
                                        nent[BIT_REMOTE] = 1'b0;
                                    end
                                    tbl_we    = 1'b1;
                                    tbl_wdata = nent;
                                    n_mchg    = (nent[BIT_MASK] != ent[BIT_MASK]);
                                    n_state   = S_WNOTE;
                                end
                            end
                        end
                    end
                    CMD_LINE: begin
                        if (r_idx_ok) begin
                            active = r_job.level ^ ent[BIT_POLARITY];
                            n_pend[r_idx] = active;
                            if (active) begin
                                serve = ent[BIT_LEVEL] ? !ent[BIT_REMOTE] : !pend_bit;
                                if (!serve) begin
                                    n_status = ST_COAL;
                                end else if (ent[BIT_MASK]) begin
                                    n_status = ST_MASKED;
                                end else begin
                                    n_status = ST_DELIV;
                                    n_state  = S_SVC;
                                end
                            end
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end

            S_WNOTE: begin
                if (!r_mchg || can_emit) begin
                    if (r_mchg) begin
                        emit              = 1'b1;
                        n_out.result_kind = KIND_MASK;
                        n_out.note_pin    = 5'(r_idx);
                        n_out.note_masked = ent[BIT_MASK];
                        n_mchg            = 1'b0;
                    end
                    if (ent[BIT_LEVEL] && pend_bit && !ent[BIT_MASK]) begin
                        n_state = S_SVC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_SVC: begin
                if (can_emit) begin
                    emit                    = 1'b1;
                    n_out.result_kind       = KIND_MSG;
                    n_out.msg_dest          = (r_idx == '0) ? i_cfg.boot_cpu_id
                                                            : ent[63:56];
                    n_out.msg_vector        = ent[7:0];
                    n_out.msg_dest_logical  = (r_idx == '0) ? 1'b0
                                                            : ent[BIT_DEST_LOGICAL];
                    n_out.msg_level_trig    = ent[BIT_LEVEL];
                    n_out.msg_delivery_mode = ent[10:8];
                    n_out.note_pin          = 5'(r_idx);
                    if (ent[BIT_LEVEL]) begin
                        tbl_we    = 1'b1;
                        tbl_wdata = ent | (64'h1 << BIT_REMOTE);
                    end
                    if (!r_eoi) begin
                        n_state = S_DONE;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_EOI;
                    end
                end
            end

            S_EOI: begin
                if (ent[7:0] != r_job.vector || can_emit) begin
                    if (ent[7:0] == r_job.vector) begin
                        emit              = 1'b1;
                        n_out.result_kind = KIND_ACK;
                        n_out.note_pin    = 5'(r_idx);
                    end
                    if (ent[7:0] == r_job.vector && r_job.eoi_level
                        && ent[BIT_LEVEL]) begin
                        tbl_we    = 1'b1;
                        tbl_wdata = ent & ~(64'h1 << BIT_REMOTE);
                        serve     = !ent[BIT_MASK] && pend_bit;
                    end
                    if (serve) begin
                        n_state = S_SVC;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_DONE: begin
                if (can_emit) begin
                    emit              = 1'b1;
                    n_out.result_kind = KIND_DONE;
                    n_out.read_data   = r_rd;
                    n_out.line_status = r_status;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIN_COUNT; k++) begin
                r_tbl[k] <= ENTRY_RESET;
            end
        end else if (tbl_we) begin
            r_tbl[r_idx] <= tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_sel       <= '0;
            r_uid       <= '0;
            r_idx       <= '0;
            r_idx_ok    <= 1'b0;
            r_eoi       <= 1'b0;
            r_mchg      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_sel    <= n_sel;
            r_uid    <= n_uid;
            r_idx    <= n_idx;
            r_idx_ok <= n_idx_ok;
            r_eoi    <= n_eoi;
            r_mchg   <= n_mchg;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_rd     <= n_rd;
        r_status <= n_status;
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.rsp   = r_out;
endmodule
`default_nettype wire

// ----- test/tb_io_interrupt_router_core.sv -----
// Self-checking testbench of the I/O interrupt router core: predictor, scoreboard and drivers.
`default_nettype none
module tb_io_interrupt_router_core;
    timeunit 1ns;
    timeprecision 1ps;
    import iorc_pkg::*;

    localparam int NPIN      = 24;
    localparam int LIMIT     = 400000;
    localparam int TAIL_WAIT = 60;

    // Scoreboard: keeps its own copy of the router state and the queue of
    // responses that each accepted request is expected to cause.
    class router_scoreboard;
        logic [63:0] route [NPIN];
        logic [23:0] pending;
        logic [31:0] select;
        logic [3:0]  unit_id;
        logic [7:0]  boot_id;
        logic [7:0]  version;
        t_rsp        rsp_q[$];
        int          errors;

        function new();
            for (int i = 0; i < NPIN; i++) route[i] = ENTRY_RESET;
            pending = '0;
            select  = '0;
            unit_id = '0;
            boot_id = 8'd0;
            version = 8'd17;
            errors  = 0;
        endfunction

        function void set_cfg(logic idx, logic [7:0] val);
            if (idx == 1'b0) boot_id = val;
            else version = val;
        endfunction

        function void push_notice(t_kind kind, int p, logic m);
            t_rsp r;
            r = '0;
            r.result_kind = kind;
            r.note_pin    = p[4:0];
            r.note_masked = m;
            rsp_q.push_back(r);
        endfunction

        // Deliver one entry unless masked.
        function t_status deliver(int p);
            t_rsp        r;
            logic [63:0] e;
            e = route[p];
            if (e[BIT_MASK]) return ST_MASKED;
            r = '0;
            r.result_kind       = KIND_MSG;
            r.msg_dest          = (p == 0) ? boot_id : e[63:56];
            r.msg_vector        = e[7:0];
            r.msg_dest_logical  = (p == 0) ? 1'b0 : e[BIT_DEST_LOGICAL];
            r.msg_level_trig    = e[BIT_LEVEL];
            r.msg_delivery_mode = e[10:8];
            r.note_pin          = p[4:0];
            rsp_q.push_back(r);
            if (e[BIT_LEVEL]) route[p][BIT_REMOTE] = 1'b1;
            return ST_DELIV;
        endfunction

        function logic [31:0] window_value();
            logic [31:0] idx;
            logic [63:0] e;
            if (select == SEL_VERSION) return {8'd0, 8'(NPIN - 1), 8'd0, version};
            if (select == SEL_ID || select == SEL_ARB) return {4'd0, unit_id, 24'd0};
            idx = (select - TABLE_BASE) >> 1;
            e = (idx < NPIN) ? route[idx] : '1;
            return select[0] ? e[63:32] : e[31:0];
        endfunction

        function void window_write(logic [31:0] val);
            logic [31:0] idx;
            logic        was_masked;
            t_status     unused;
            if (select == SEL_VERSION || select == SEL_ARB) return;
            if (select == SEL_ID) begin
                unit_id = val[27:24];
                return;
            end
            idx = (select - TABLE_BASE) >> 1;
            if (idx >= NPIN) return;
            was_masked = route[idx][BIT_MASK];
            if (select[0]) begin
                route[idx][63:32] = val;
            end else begin
                route[idx][31:0] = val;
                route[idx][BIT_REMOTE] = 1'b0;
            end
            if (was_masked != route[idx][BIT_MASK])
                push_notice(KIND_MASK, idx, route[idx][BIT_MASK]);
            if (route[idx][BIT_LEVEL] && pending[idx]) unused = deliver(idx);
        endfunction

        function t_status line_change(logic [4:0] p, logic lvl);
            logic [63:0] e;
            logic [23:0] old;
            logic        fire;
            if (p >= NPIN) return ST_NONE;
            e = route[p];
            old = pending;
            if ((lvl ^ e[BIT_POLARITY]) == 1'b0) begin
                pending[p] = 1'b0;
                return ST_NONE;
            end
            pending[p] = 1'b1;
            fire = e[BIT_LEVEL] ? !e[BIT_REMOTE] : (old != pending);
            return fire ? deliver(p) : ST_COAL;
        endfunction

        function void end_of_interrupt(logic [7:0] vec, logic lvl);
            t_status unused;
            for (int i = 0; i < NPIN; i++) begin
                if (route[i][7:0] == vec) begin
                    push_notice(KIND_ACK, i, 1'b0);
                    if (lvl && route[i][BIT_LEVEL]) begin
                        route[i][BIT_REMOTE] = 1'b0;
                        if (!route[i][BIT_MASK] && pending[i]) unused = deliver(i);
                    end
                end
            end
        endfunction

        // Note an accepted request and queue the responses it causes.
        function void note_request(t_req q);
            t_rsp        done;
            logic [31:0] v;
            logic        full;
            done = '0;
            full = (q.access_bytes == 4'd4 || q.access_bytes == 4'd8);
            case (q.command)
                CMD_READ: begin
                    v = (q.reg_offset == OFF_SELECT) ? select :
                        (q.reg_offset == OFF_WINDOW) ? window_value() : 32'd0;
                    if (q.access_bytes == 4'd1) done.read_data = {24'd0, v[7:0]};
                    else if (q.access_bytes == 4'd2) done.read_data = {16'd0, v[15:0]};
                    else if (full) done.read_data = v;
                end
                CMD_WRITE: begin
                    if (full && q.reg_offset == OFF_SELECT) select = q.write_data;
                    else if (full && q.reg_offset == OFF_WINDOW) window_write(q.write_data);
                end
                CMD_LINE: done.line_status = line_change(q.pin, q.line_level);
                default: end_of_interrupt(q.eoi_vector, q.eoi_level_trig);
            endcase
            done.result_kind = KIND_DONE;
            done.last = 1'b1;
            rsp_q.push_back(done);
        endfunction

        function void cmp(string field, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
                         $realtime, field, exp_v, act_v);
                errors++;
            end
        endfunction

        // Check one response against the oldest expectation.
        function void check_response(t_rsp got);
            t_rsp e;
            if (rsp_q.size() == 0) begin
                $display("%0t: unexpected response: expected none, actual 0x%0h",
                         $realtime, got);
                errors++;
                return;
            end
            e = rsp_q.pop_front();
            cmp("result_kind", e.result_kind, got.result_kind);
            cmp("read_data", e.read_data, got.read_data);
            cmp("line_status", e.line_status, got.line_status);
            cmp("msg_dest", e.msg_dest, got.msg_dest);
            cmp("msg_vector", e.msg_vector, got.msg_vector);
            cmp("msg_dest_logical", e.msg_dest_logical, got.msg_dest_logical);
            cmp("msg_level_trig", e.msg_level_trig, got.msg_level_trig);
            cmp("msg_delivery_mode", e.msg_delivery_mode, got.msg_delivery_mode);
            cmp("note_pin", e.note_pin, got.note_pin);
            cmp("note_masked", e.note_masked, got.note_masked);
            cmp("last", e.last, got.last);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [0:0] i_cfg_index;
    logic [7:0] i_cfg_wdata;

    iorc_req_if req_if ();
    iorc_rsp_if rsp_if ();

    io_interrupt_router_core #(.PIN_COUNT(NPIN)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    router_scoreboard sb;
    bit               quiet;     // set in the last part of the run: no idling at all
    int               ready_gap;
    int               cycles;

    initial sb = new();

    // 4 ns clock: high for 2, low for 2.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Stall the response side in random bursts.
    always @(negedge i_clk) begin
        if (ready_gap > 0) begin
            rsp_if.ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            ready_gap <= $urandom_range(0, 3);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Sample responses at the rising edge and check them.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.rsp);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("io_interrupt_router_core test failed");
            $finish;
        end
    end

    // Drive one request: optional idle burst, then hold valid until accepted.
    task automatic send(t_req q);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.item  <= q;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(q);
    endtask

    // Drop valid and wait until every expected response has come.
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.rsp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    // Write one configuration register; only called with the block idle.
    task automatic write_cfg(logic idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_cfg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_req mk(t_cmd c, logic [7:0] off, logic [3:0] len,
                                logic [31:0] data);
        t_req q;
        q = '0;
        q.command      = c;
        q.reg_offset   = off;
        q.access_bytes = len;
        q.write_data   = data;
        return q;
    endfunction

    task automatic reg_wr(logic [7:0] off, logic [31:0] data);
        send(mk(CMD_WRITE, off, 4'd4, data));
    endtask

    task automatic reg_rd(logic [7:0] off, logic [3:0] len);
        send(mk(CMD_READ, off, len, 32'd0));
    endtask

    task automatic line(logic [4:0] p, logic lvl);
        t_req q;
        q = mk(CMD_LINE, 8'd0, 4'd4, 32'd0);
        q.pin = p;
        q.line_level = lvl;
        send(q);
    endtask

    task automatic eoi(logic [7:0] vec, logic lvl);
        t_req q;
        q = mk(CMD_EOI, 8'd0, 4'd4, 32'd0);
        q.eoi_vector = vec;
        q.eoi_level_trig = lvl;
        send(q);
    endtask

    // Program both halves of one routing entry through select and window.
    task automatic program_entry(int p, logic [31:0] lo, logic [31:0] hi);
        reg_wr(OFF_SELECT, 32'(TABLE_BASE + 2 * p + 1));
        reg_wr(OFF_WINDOW, hi);
        reg_wr(OFF_SELECT, 32'(TABLE_BASE + 2 * p));
        reg_wr(OFF_WINDOW, lo);
    endtask

    // Random low word: vector from a small pool so end of interrupt matches.
    function automatic logic [31:0] rand_low();
        logic [31:0] w;
        w = $urandom;
        w[7:0] = 8'h40 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) w[BIT_MASK] = 1'b0;
        return w;
    endfunction

    // One random request, mostly well formed, some pure noise.
    task automatic random_request();
        t_req q;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            program_entry($urandom_range(0, NPIN - 1), rand_low(), $urandom);
        end else if (pick < 45) begin
            line($urandom_range(0, 9) == 0 ? 5'($urandom_range(NPIN, 31))
                                           : 5'($urandom_range(0, NPIN - 1)),
                 1'($urandom));
        end else if (pick < 65) begin
            eoi($urandom_range(0, 5) == 0 ? 8'($urandom) : 8'h40 + 8'($urandom_range(0, 3)),
                1'($urandom));
        end else if (pick < 80) begin
            reg_wr(OFF_SELECT, $urandom_range(0, 7) == 0 ? $urandom
                                                         : 32'($urandom_range(0, 'h40)));
            reg_rd(OFF_WINDOW, 4'($urandom_range(0, 15)));
        end else begin
            q = t_req'(61'({$urandom, $urandom}));
            if ($urandom_range(0, 1)) q.reg_offset = $urandom_range(0, 1) ? OFF_WINDOW
                                                                          : OFF_SELECT;
            send(q);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.item  = '0;
        rsp_if.ready = 1'b0;
        ready_gap    = 0;
        quiet        = 1'b0;
        cycles       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: id, version and arbitration registers, sizes, offsets.
        reg_rd(OFF_WINDOW, 4'd4);                       // id register after reset
        reg_wr(OFF_WINDOW, 32'hffff_ffff);              // id write keeps bits 27:24
        reg_wr(OFF_SELECT, SEL_VERSION);
        reg_rd(OFF_WINDOW, 4'd8);
        reg_wr(OFF_WINDOW, 32'h1234_5678);              // version ignores writes
        reg_wr(OFF_SELECT, SEL_ARB);
        reg_wr(OFF_WINDOW, 32'h0);                      // arbitration id ignores writes
        reg_rd(OFF_WINDOW, 4'd2);
        reg_wr(OFF_SELECT, 32'hffff_ffff);              // select beyond the table
        reg_rd(OFF_WINDOW, 4'd1);
        reg_rd(OFF_SELECT, 4'd3);                       // odd size reads zero
        send(mk(CMD_WRITE, OFF_SELECT, 4'd2, 32'h0));   // short write ignored
        reg_rd(OFF_SELECT, 4'd8);
        send(mk(CMD_WRITE, 8'hff, 4'd8, 32'hdead_beef)); // other offset
        reg_rd(8'hff, 4'd4);
        // Pin 0 goes to the boot processor; pin beyond the count does nothing.
        program_entry(0, 32'h0000_0841, 32'hff00_0000);
        line(5'd0, 1'b1);
        line(5'd31, 1'b1);
        line(5'd0, 1'b1);                               // edge coalesced
        // Level entry, active low: deliver, coalesce, then end of interrupt.
        program_entry(5, 32'h0000_a742, 32'h3c00_0000);
        line(5'd5, 1'b0);
        line(5'd5, 1'b0);
        eoi(8'h41, 1'b0);                               // edge end of interrupt
        eoi(8'h42, 1'b1);                               // level redelivers
        eoi(8'h41, 1'b1);                               // trigger disagreement
        line(5'd5, 1'b1);                               // line inactive
        drain();

        // Random phases under several register settings, extremes included.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin write_cfg(1'b0, 8'hff); write_cfg(1'b1, 8'h00); end
                1: begin write_cfg(1'b0, 8'h00); write_cfg(1'b1, 8'hff); end
                2: begin write_cfg(1'b0, 8'($urandom)); write_cfg(1'b1, 8'($urandom)); end
                default: begin write_cfg(1'b0, 8'h5a); write_cfg(1'b1, 8'h11); end
            endcase
            if (phase == 3) quiet = 1'b1;
            for (int n = 0; n < 25; n++) begin
                random_request();
                if (phase == 1 && n == 20) begin
                    // Hold off the sender until the block has caught up.
                    @(negedge i_clk);
                    req_if.valid <= 1'b0;
                    while (sb.rsp_q.size() != 0) @(posedge i_clk);
                end
            end
            reg_wr(OFF_SELECT, SEL_VERSION);
            reg_rd(OFF_WINDOW, 4'd4);
            drain();
        end

        if (sb.errors == 0 && sb.rsp_q.size() == 0) begin
            $display("io_interrupt_router_core test passed");
        end else begin
            $display("io_interrupt_router_core test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
